// ===== rtl/core/sifr_pkg.sv =====
// ----------------------------------------------------------------------------
// sifr_pkg
// Types and constants shared by the stuffed information frame receiver.
// ----------------------------------------------------------------------------
package sifr_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned PayloadLenW = 10;
  localparam int unsigned DefaultMaxPayload = 512;
  localparam int unsigned ApbAddrW    = 5;
  localparam int unsigned ApbDataW    = 32;

  localparam logic [ByteW-1:0] StuffMask = 8'h20;

  localparam logic [ByteW-1:0] FlagReset    = 8'h7E;
  localparam logic [ByteW-1:0] EscapeReset  = 8'h7D;
  localparam logic [ByteW-1:0] AddressReset = 8'h03;
  localparam logic [ByteW-1:0] CtrlSeq0Reset = 8'h00;
  localparam logic [ByteW-1:0] CtrlSeq1Reset = 8'h40;

  typedef enum logic [2:0] {
    RegFlag     = 3'd0,
    RegEscape   = 3'd1,
    RegAddress  = 3'd2,
    RegCtrlSeq0 = 3'd3,
    RegCtrlSeq1 = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    KindData   = 2'd0,
    KindAccept = 2'd1,
    KindDup    = 2'd2,
    KindReject = 2'd3
  } kind_e;

  typedef enum logic [5:0] {
    PhHunt = 6'b000001,
    PhFlag = 6'b000010,
    PhAddr = 6'b000100,
    PhCtrl = 6'b001000,
    PhData = 6'b010000,
    PhEsc  = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] flag_byte;
    logic [ByteW-1:0] escape_byte;
    logic [ByteW-1:0] address_byte;
    logic [ByteW-1:0] control_seq_zero;
    logic [ByteW-1:0] control_seq_one;
  } cfg_t;

  typedef struct packed {
    logic                   valid;
    kind_e                  kind;
    logic [ByteW-1:0]       payload_byte;
    logic                   ack_number;
    logic [PayloadLenW-1:0] payload_length;
    logic                   frame_end;
  } result_t;

endpackage

// ===== rtl/core/sifr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// sifr_cfg_regs
// APB register file holding the framing byte values.
// ----------------------------------------------------------------------------
module sifr_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sifr_pkg::ApbAddrW-1:0]  paddr,
  input  logic [sifr_pkg::ApbDataW-1:0]  pwdata,
  output logic [sifr_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready,
  output sifr_pkg::cfg_t                 cfg_o
);

  sifr_pkg::cfg_t   cfg_q, cfg_d;
  sifr_pkg::reg_idx_e idx;
  logic             wr_en;
  logic [sifr_pkg::ByteW-1:0] wbyte;
  logic [sifr_pkg::ByteW-1:0] rbyte;

  assign idx   = sifr_pkg::reg_idx_e'(paddr[sifr_pkg::ApbAddrW-1:2]);
  assign wr_en = psel && penable && pwrite;
  assign wbyte = pwdata[sifr_pkg::ByteW-1:0];
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        sifr_pkg::RegFlag:     cfg_d.flag_byte        = wbyte;
        sifr_pkg::RegEscape:   cfg_d.escape_byte      = wbyte;
        sifr_pkg::RegAddress:  cfg_d.address_byte     = wbyte;
        sifr_pkg::RegCtrlSeq0: cfg_d.control_seq_zero = wbyte;
        sifr_pkg::RegCtrlSeq1: cfg_d.control_seq_one  = wbyte;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      sifr_pkg::RegFlag:     rbyte = cfg_q.flag_byte;
      sifr_pkg::RegEscape:   rbyte = cfg_q.escape_byte;
      sifr_pkg::RegAddress:  rbyte = cfg_q.address_byte;
      sifr_pkg::RegCtrlSeq0: rbyte = cfg_q.control_seq_zero;
      sifr_pkg::RegCtrlSeq1: rbyte = cfg_q.control_seq_one;
      default:               rbyte = '0;
    endcase
  end

  assign prdata = {{(sifr_pkg::ApbDataW-sifr_pkg::ByteW){1'b0}}, rbyte};
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag_byte        <= sifr_pkg::FlagReset;
      cfg_q.escape_byte      <= sifr_pkg::EscapeReset;
      cfg_q.address_byte     <= sifr_pkg::AddressReset;
      cfg_q.control_seq_zero <= sifr_pkg::CtrlSeq0Reset;
      cfg_q.control_seq_one  <= sifr_pkg::CtrlSeq1Reset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/core/sifr_frame_core.sv =====
// ----------------------------------------------------------------------------
// sifr_frame_core
// Header hunt, destuffing, data check and frame status for one byte a cycle while step_i is high.
// ----------------------------------------------------------------------------
module sifr_frame_core #(
  parameter int unsigned MaxPayload = sifr_pkg::DefaultMaxPayload
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [sifr_pkg::ByteW-1:0] byte_i,
  input  sifr_pkg::cfg_t             cfg_i,
  output sifr_pkg::result_t          res_o
);

  localparam logic [sifr_pkg::PayloadLenW-1:0] MaxLen =
    sifr_pkg::PayloadLenW'(MaxPayload);

  sifr_pkg::phase_e phase_q, phase_d;
  logic frame_seq_q, frame_seq_d;
  logic expected_seq_q, expected_seq_d;
  logic [sifr_pkg::ByteW-1:0] held_byte_q, held_byte_d;
  logic held_valid_q, held_valid_d;
  logic [sifr_pkg::ByteW-1:0] running_xor_q, running_xor_d;
  logic [sifr_pkg::PayloadLenW-1:0] byte_count_q, byte_count_d;

  logic [sifr_pkg::ByteW-1:0] unstuffed;
  logic [sifr_pkg::ByteW-1:0] push_val;
  logic [sifr_pkg::ByteW-1:0] ctrl_sel;
  logic [sifr_pkg::ByteW-1:0] hdr_check;
  sifr_pkg::phase_e fallback;
  logic do_push;

  assign fallback  = (byte_i == cfg_i.flag_byte) ? sifr_pkg::PhFlag : sifr_pkg::PhHunt;
  assign ctrl_sel  = frame_seq_q ? cfg_i.control_seq_one : cfg_i.control_seq_zero;
  assign hdr_check = cfg_i.address_byte ^ ctrl_sel;

  always_comb begin
    if (byte_i == (cfg_i.flag_byte ^ sifr_pkg::StuffMask)) begin
      unstuffed = cfg_i.flag_byte;
    end else if (byte_i == (cfg_i.escape_byte ^ sifr_pkg::StuffMask)) begin
      unstuffed = cfg_i.escape_byte;
    end else begin
      unstuffed = byte_i;
    end
  end

  always_comb begin
    phase_d        = phase_q;
    frame_seq_d    = frame_seq_q;
    expected_seq_d = expected_seq_q;
    held_byte_d    = held_byte_q;
    held_valid_d   = held_valid_q;
    running_xor_d  = running_xor_q;
    byte_count_d   = byte_count_q;
    do_push        = 1'b0;
    push_val       = byte_i;
    res_o          = '0;
    res_o.kind     = sifr_pkg::KindData;

    case (phase_q)
      sifr_pkg::PhFlag: begin
        phase_d = (byte_i == cfg_i.address_byte) ? sifr_pkg::PhAddr : fallback;
      end
      sifr_pkg::PhAddr: begin
        if (byte_i == cfg_i.control_seq_zero) begin
          frame_seq_d = 1'b0;
          phase_d     = sifr_pkg::PhCtrl;
        end else if (byte_i == cfg_i.control_seq_one) begin
          frame_seq_d = 1'b1;
          phase_d     = sifr_pkg::PhCtrl;
        end else begin
          phase_d = fallback;
        end
      end
      sifr_pkg::PhCtrl: begin
        if (byte_i == hdr_check) begin
          if (frame_seq_q != expected_seq_q) begin
            res_o.valid      = 1'b1;
            res_o.kind       = sifr_pkg::KindDup;
            res_o.ack_number = expected_seq_q;
            res_o.frame_end  = 1'b1;
            phase_d          = sifr_pkg::PhHunt;
          end else begin
            phase_d       = sifr_pkg::PhData;
            held_byte_d   = '0;
            held_valid_d  = 1'b0;
            running_xor_d = '0;
            byte_count_d  = '0;
          end
        end else begin
          phase_d = fallback;
        end
      end
      sifr_pkg::PhData: begin
        if (byte_i == cfg_i.escape_byte) begin
          phase_d = sifr_pkg::PhEsc;
        end else if (byte_i == cfg_i.flag_byte) begin
          res_o.valid     = 1'b1;
          res_o.frame_end = 1'b1;
          phase_d         = sifr_pkg::PhHunt;
          if (held_valid_q && (held_byte_q == running_xor_q)) begin
            res_o.kind           = sifr_pkg::KindAccept;
            res_o.ack_number     = ~expected_seq_q;
            res_o.payload_length = byte_count_q;
            expected_seq_d       = ~expected_seq_q;
          end else begin
            res_o.kind       = sifr_pkg::KindReject;
            res_o.ack_number = expected_seq_q;
          end
        end else begin
          do_push = 1'b1;
        end
      end
      sifr_pkg::PhEsc: begin
        phase_d  = sifr_pkg::PhData;
        push_val = unstuffed;
        do_push  = 1'b1;
      end
      default: begin
        phase_d = fallback;
      end
    endcase

    if (do_push) begin
      if (held_valid_q && (byte_count_q >= MaxLen)) begin
        res_o.valid      = 1'b1;
        res_o.kind       = sifr_pkg::KindReject;
        res_o.ack_number = expected_seq_q;
        res_o.frame_end  = 1'b1;
        phase_d          = sifr_pkg::PhHunt;
      end else begin
        if (held_valid_q) begin
          res_o.valid        = 1'b1;
          res_o.kind         = sifr_pkg::KindData;
          res_o.payload_byte = held_byte_q;
          running_xor_d      = running_xor_q ^ held_byte_q;
          byte_count_d       = byte_count_q + 1'b1;
        end
        held_byte_d  = push_val;
        held_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= sifr_pkg::PhHunt;
      frame_seq_q    <= 1'b0;
      expected_seq_q <= 1'b0;
      held_byte_q    <= '0;
      held_valid_q   <= 1'b0;
      running_xor_q  <= '0;
      byte_count_q   <= '0;
    end else if (step_i) begin
      phase_q        <= phase_d;
      frame_seq_q    <= frame_seq_d;
      expected_seq_q <= expected_seq_d;
      held_byte_q    <= held_byte_d;
      held_valid_q   <= held_valid_d;
      running_xor_q  <= running_xor_d;
      byte_count_q   <= byte_count_d;
    end
  end

endmodule

// ===== rtl/core/stuffed_info_frame_receiver.sv =====
// A result follows its byte transaction through the input register, then the
// result register. Throughput: one byte per cycle while the result register is
// not held by out_ready_i; the frame state update sits between those registers.
// Reset: asynchronous, active low; clears the frame state and restores the
// default framing bytes (flag 0x7E, escape 0x7D, address 0x03, 0x00, 0x40).
// ----------------------------------------------------------------------------
// stuffed_info_frame_receiver
// Byte-stuffed information frame receiver with APB configuration.
// ----------------------------------------------------------------------------
module stuffed_info_frame_receiver #(
  parameter int unsigned MaxPayload = sifr_pkg::DefaultMaxPayload
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sifr_pkg::ApbAddrW-1:0]    paddr,
  input  logic [sifr_pkg::ApbDataW-1:0]    pwdata,
  output logic [sifr_pkg::ApbDataW-1:0]    prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [sifr_pkg::ByteW-1:0]       rx_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       kind_o,
  output logic [sifr_pkg::ByteW-1:0]       payload_byte_o,
  output logic                             ack_number_o,
  output logic [sifr_pkg::PayloadLenW-1:0] payload_length_o,
  output logic                             frame_end_o
);

  sifr_pkg::cfg_t    cfg;
  sifr_pkg::result_t res;
  sifr_pkg::result_t out_q, out_d;

  logic in_vld_q, in_vld_d;
  logic [sifr_pkg::ByteW-1:0] in_byte_q, in_byte_d;
  logic advance;

  sifr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sifr_frame_core #(
    .MaxPayload (MaxPayload)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign advance    = in_vld_q && (!out_q.valid || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_comb begin
    in_vld_d  = in_vld_q;
    in_byte_d = in_byte_q;
    if (in_valid_i && in_ready_o) begin
      in_vld_d  = 1'b1;
      in_byte_d = rx_byte_i;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_d = out_q;
    if (advance) begin
      out_d = res;
    end else if (out_ready_i) begin
      out_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      in_byte_q <= '0;
      out_q     <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      in_byte_q <= in_byte_d;
      out_q     <= out_d;
    end
  end

  assign out_valid_o      = out_q.valid;
  assign kind_o           = out_q.kind;
  assign payload_byte_o   = out_q.payload_byte;
  assign ack_number_o     = out_q.ack_number;
  assign payload_length_o = out_q.payload_length;
  assign frame_end_o      = out_q.frame_end;

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stuffed information frame receiver. Line bytes
// (directed frames, then random frames, noise and broken headers under several
// framing settings) go through a valid/ready driver. A behavioral decoder
// tracks each accepted byte, and a monitor compares every report the block
// returns with the decoder's oldest pending one.
// ----------------------------------------------------------------------------
module testbench;
  import sifr_pkg::*;

  localparam int unsigned MaxFrame    = DefaultMaxPayload;
  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned DrainCycles = 6;

  typedef struct packed {
    kind_e                  kind;
    logic [ByteW-1:0]       data;
    logic                   ack;
    logic [PayloadLenW-1:0] len;
    logic                   closes;
  } report_t;

  logic                   clk_i;
  logic                   rst_ni      = 1'b0;
  logic                   psel        = 1'b0;
  logic                   penable     = 1'b0;
  logic                   pwrite      = 1'b0;
  logic [ApbAddrW-1:0]    paddr       = '0;
  logic [ApbDataW-1:0]    pwdata      = '0;
  logic [ApbDataW-1:0]    prdata;
  logic                   pready;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  logic [ByteW-1:0]       rx_byte_i   = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [1:0]             kind_o;
  logic [ByteW-1:0]       payload_byte_o;
  logic                   ack_number_o;
  logic [PayloadLenW-1:0] payload_length_o;
  logic                   frame_end_o;

  // decoder state
  cfg_t                   frm_cfg;
  phase_e                 rx_phase;
  logic                   rx_seq;
  logic                   want_seq;
  logic [ByteW-1:0]       hold_byte;
  logic                   hold_valid;
  logic [ByteW-1:0]       data_xor;
  logic [PayloadLenW-1:0] data_count;

  logic [ByteW-1:0] line_bytes [$];
  report_t          pending_reports [$];
  report_t          got_r;
  report_t          want_r;
  int unsigned      mismatch_count = 0;
  int unsigned      queued = 0;
  int unsigned      src_wait;
  int unsigned      sink_wait;
  int unsigned      idle_cycles = 0;
  logic             burst_mode = 1'b0;
  logic             gen_seq = 1'b0;

  stuffed_info_frame_receiver #(
    .MaxPayload(MaxFrame)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .payload_byte_o  (payload_byte_o),
    .ack_number_o    (ack_number_o),
    .payload_length_o(payload_length_o),
    .frame_end_o     (frame_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_wait();
    if (burst_mode || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  // ---------------------------------------------------------------- decoder
  task automatic push_report(input kind_e kind, input logic [ByteW-1:0] data,
                             input logic ack, input logic [PayloadLenW-1:0] len,
                             input logic closes);
    report_t r;
    r.kind   = kind;
    r.data   = data;
    r.ack    = ack;
    r.len    = len;
    r.closes = closes;
    pending_reports.push_back(r);
  endtask

  task automatic close_frame(input kind_e kind, input logic ack,
                             input logic [PayloadLenW-1:0] len);
    push_report(kind, '0, ack, len, 1'b1);
    rx_phase = PhHunt;
  endtask

  function automatic phase_e after_stray(input logic [ByteW-1:0] b);
    return (b == frm_cfg.flag_byte) ? PhFlag : PhHunt;
  endfunction

  // payload leaves one byte late; the held byte becomes the data check
  task automatic take_payload(input logic [ByteW-1:0] b);
    if (hold_valid) begin
      if (data_count >= MaxFrame) begin
        close_frame(KindReject, want_seq, '0);
        return;
      end
      push_report(KindData, hold_byte, 1'b0, '0, 1'b0);
      data_xor   = data_xor ^ hold_byte;
      data_count = data_count + 1'b1;
    end
    hold_byte  = b;
    hold_valid = 1'b1;
  endtask

  task automatic decode_line_byte(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] ctrl;
    logic [ByteW-1:0] plain;
    case (rx_phase)
      PhFlag: begin
        if (b == frm_cfg.address_byte) rx_phase = PhAddr;
        else rx_phase = after_stray(b);
      end
      PhAddr: begin
        if (b == frm_cfg.control_seq_zero) begin
          rx_seq   = 1'b0;
          rx_phase = PhCtrl;
        end else if (b == frm_cfg.control_seq_one) begin
          rx_seq   = 1'b1;
          rx_phase = PhCtrl;
        end else begin
          rx_phase = after_stray(b);
        end
      end
      PhCtrl: begin
        ctrl = rx_seq ? frm_cfg.control_seq_one : frm_cfg.control_seq_zero;
        if (b != (frm_cfg.address_byte ^ ctrl)) begin
          rx_phase = after_stray(b);
        end else if (rx_seq != want_seq) begin
          close_frame(KindDup, want_seq, '0);
        end else begin
          rx_phase   = PhData;
          hold_byte  = '0;
          hold_valid = 1'b0;
          data_xor   = '0;
          data_count = '0;
        end
      end
      PhData: begin
        if (b == frm_cfg.escape_byte) begin
          rx_phase = PhEsc;
        end else if (b == frm_cfg.flag_byte) begin
          if (hold_valid && hold_byte == data_xor) begin
            want_seq = ~want_seq;
            close_frame(KindAccept, want_seq, data_count);
          end else begin
            close_frame(KindReject, want_seq, '0);
          end
        end else begin
          take_payload(b);
        end
      end
      PhEsc: begin
        rx_phase = PhData;
        if (b == (frm_cfg.flag_byte ^ StuffMask)) plain = frm_cfg.flag_byte;
        else if (b == (frm_cfg.escape_byte ^ StuffMask)) plain = frm_cfg.escape_byte;
        else plain = b;
        take_payload(plain);
      end
      default: begin
        rx_phase = after_stray(b);
      end
    endcase
  endtask

  // ---------------------------------------------------------------- traffic
  task automatic send(input logic [ByteW-1:0] b);
    line_bytes.push_back(b);
    queued++;
  endtask

  function automatic logic [ByteW-1:0] line_noise();
    case ($urandom_range(0, 9))
      0: return frm_cfg.flag_byte;
      1: return frm_cfg.escape_byte;
      2: return frm_cfg.flag_byte ^ StuffMask;
      3: return frm_cfg.escape_byte ^ StuffMask;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // bytes that map to themselves after an escape are sometimes sent escaped
  task automatic send_data(input logic [ByteW-1:0] d);
    if (d != (frm_cfg.flag_byte ^ StuffMask) && d != (frm_cfg.escape_byte ^ StuffMask) &&
        $urandom_range(0, 7) == 0) begin
      send(frm_cfg.escape_byte);
      send(d);
    end else if (d == frm_cfg.flag_byte || d == frm_cfg.escape_byte) begin
      send(frm_cfg.escape_byte);
      send(d ^ StuffMask);
    end else begin
      send(d);
    end
  endtask

  task automatic queue_info_frame(input logic seq, input int unsigned n,
                                  input bit has_check, input bit bad_check);
    logic [ByteW-1:0] ctrl;
    logic [ByteW-1:0] chk;
    logic [ByteW-1:0] d;
    ctrl = seq ? frm_cfg.control_seq_one : frm_cfg.control_seq_zero;
    chk  = '0;
    send(frm_cfg.flag_byte);
    send(frm_cfg.address_byte);
    send(ctrl);
    send(frm_cfg.address_byte ^ ctrl);
    if (has_check) begin
      repeat (n) begin
        d   = line_noise();
        chk = chk ^ d;
        send_data(d);
      end
      if (bad_check) chk = chk ^ 8'($urandom_range(1, 255));
      send_data(chk);
    end
    send(frm_cfg.flag_byte);
    if (seq == gen_seq && has_check && !bad_check && n <= MaxFrame) gen_seq = ~gen_seq;
  endtask

  task automatic queue_traffic(input int unsigned max_len);
    int unsigned      pick;
    int unsigned      cut;
    int unsigned      n;
    logic             seq;
    logic [ByteW-1:0] hdr [4];
    pick   = $urandom_range(0, 99);
    seq    = ($urandom_range(0, 4) == 0) ? ~gen_seq : gen_seq;
    n      = ($urandom_range(0, 7) == 0) ? $urandom_range(0, max_len) : $urandom_range(0, 6);
    hdr[0] = frm_cfg.flag_byte;
    hdr[1] = frm_cfg.address_byte;
    hdr[2] = seq ? frm_cfg.control_seq_one : frm_cfg.control_seq_zero;
    hdr[3] = hdr[1] ^ hdr[2];
    if (pick < 12) begin
      repeat ($urandom_range(1, 8)) send(line_noise());
    end else if (pick < 22) begin
      cut = $urandom_range(1, 3);
      for (int i = 0; i < cut; i++) send(hdr[i]);
      send(line_noise());
    end else if (pick < 30) begin
      queue_info_frame(seq, 0, 1'b0, 1'b0);
    end else begin
      queue_info_frame(seq, n, 1'b1, pick < 40);
    end
  endtask

  // ---------------------------------------------------------------- config
  task automatic write_reg(input reg_idx_e idx, input logic [ByteW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'({idx, 2'b00});
    pwdata  <= ApbDataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegFlag:     frm_cfg.flag_byte        = value;
      RegEscape:   frm_cfg.escape_byte      = value;
      RegAddress:  frm_cfg.address_byte     = value;
      RegCtrlSeq0: frm_cfg.control_seq_zero = value;
      RegCtrlSeq1: frm_cfg.control_seq_one  = value;
      default: ;
    endcase
  endtask

  // wait until every byte is taken and every report has come back
  task automatic drain();
    @(negedge clk_i);
    while (line_bytes.size() != 0 || in_valid_i || pending_reports.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    int unsigned      target;
    int unsigned      budget;
    logic [ByteW-1:0] f, e, a, c0, c1;
    frm_cfg.flag_byte        = FlagReset;
    frm_cfg.escape_byte      = EscapeReset;
    frm_cfg.address_byte     = AddressReset;
    frm_cfg.control_seq_zero = CtrlSeq0Reset;
    frm_cfg.control_seq_one  = CtrlSeq1Reset;
    rx_phase   = PhHunt;
    rx_seq     = 1'b0;
    want_seq   = 1'b0;
    hold_byte  = '0;
    hold_valid = 1'b0;
    data_xor   = '0;
    data_count = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // flag restart, stuffed flag and escape, 0xFF, duplicate, empty frame,
    // check-only frame of length zero
    line_bytes = '{
      FlagReset, FlagReset, AddressReset, CtrlSeq0Reset, AddressReset ^ CtrlSeq0Reset,
      EscapeReset, FlagReset ^ StuffMask, EscapeReset, EscapeReset ^ StuffMask, 8'hFF,
      FlagReset ^ EscapeReset ^ 8'hFF, FlagReset,
      8'h00, FlagReset, AddressReset, CtrlSeq0Reset, AddressReset ^ CtrlSeq0Reset,
      FlagReset, AddressReset, CtrlSeq1Reset, AddressReset ^ CtrlSeq1Reset, FlagReset,
      FlagReset, AddressReset, CtrlSeq1Reset, AddressReset ^ CtrlSeq1Reset, 8'h00, FlagReset
    };
    drain();

    for (int ph = 1; ph <= 8; ph++) begin
      case (ph)
        1: begin
          f = 8'h00; e = 8'hFF; a = 8'hFF; c0 = 8'h00; c1 = 8'hFF; budget = 100;
        end
        2: begin
          f = 8'hFF; e = 8'h00; a = 8'h00; c0 = 8'hFF; c1 = 8'h01; budget = 100;
        end
        3: begin
          f = FlagReset; e = EscapeReset; a = AddressReset;
          c0 = CtrlSeq0Reset; c1 = CtrlSeq1Reset; budget = 40;
        end
        4: begin
          f = 8'h55; e = 8'h55; a = 8'hA5; c0 = 8'h3C; c1 = 8'h3C; budget = 40;
        end
        default: begin
          f  = 8'($urandom_range(0, 255));
          e  = f ^ 8'($urandom_range(1, 255));
          a  = 8'($urandom_range(0, 255));
          c0 = 8'($urandom_range(0, 255));
          c1 = 8'($urandom_range(0, 255));
          budget = 60;
        end
      endcase
      write_reg(RegFlag, f);
      write_reg(RegEscape, e);
      write_reg(RegAddress, a);
      write_reg(RegCtrlSeq0, c0);
      write_reg(RegCtrlSeq1, c1);
      burst_mode = (ph == 2 || ph == 6);
      gen_seq    = want_seq;
      if (ph == 3) begin
        // one byte past the payload limit: every byte up to the limit goes out
        queue_info_frame(gen_seq, MaxFrame + 1, 1'b1, 1'b0);
      end
      target = queued + budget;
      while (queued < target) queue_traffic(40);
      drain();
    end

    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("stuffed_info_frame_receiver regression: pass");
    end else begin
      $display("stuffed_info_frame_receiver regression: fail");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      rx_byte_i  <= '0;
      src_wait = 0;
    end else begin
      if (in_valid_i && in_ready_o) decode_line_byte(rx_byte_i);
      if (!(in_valid_i && !in_ready_o)) begin
        if (src_wait != 0) begin
          src_wait--;
          in_valid_i <= 1'b0;
        end else if (line_bytes.size() != 0) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= line_bytes.pop_front();
          src_wait = pick_wait();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      sink_wait = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got_r.kind   = kind_e'(kind_o);
        got_r.data   = payload_byte_o;
        got_r.ack    = ack_number_o;
        got_r.len    = payload_length_o;
        got_r.closes = frame_end_o;
        if (pending_reports.size() == 0) begin
          if (mismatch_count < 10)
            $display("[%0t] unexpected transaction: kind %0d byte %02h ack %0d len %0d end %0d",
                     $time, got_r.kind, got_r.data, got_r.ack, got_r.len, got_r.closes);
          mismatch_count++;
        end else begin
          want_r = pending_reports.pop_front();
          if (got_r.kind !== want_r.kind || got_r.data !== want_r.data ||
              got_r.ack !== want_r.ack || got_r.len !== want_r.len ||
              got_r.closes !== want_r.closes) begin
            if (mismatch_count < 10) begin
              $write("[%0t] mismatch: exp kind %0d byte %02h ack %0d len %0d end %0d,",
                     $time, want_r.kind, want_r.data, want_r.ack, want_r.len,
                     want_r.closes);
              $display(" got kind %0d byte %02h ack %0d len %0d end %0d",
                       got_r.kind, got_r.data, got_r.ack, got_r.len, got_r.closes);
            end
            mismatch_count++;
          end
        end
        sink_wait = pick_wait();
      end else if (sink_wait != 0) begin
        sink_wait--;
      end
      out_ready_i <= (sink_wait == 0);
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("stuffed_info_frame_receiver regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
